// ----- hw/rtl/bf2d_pkg.sv -----
// shared constants, codes and types of the rgba box filter
package bf2d_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HALF_DEF  = 7;

	localparam int PIX_W      = 8;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;
	localparam int ROW_W      = 12;
	localparam int COL_OUT_W  = 10;
	localparam int PAD_W      = OUT_DATA_W - 4 * PIX_W - COL_OUT_W - ROW_W;
	localparam int HEIGHT_MAX = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int HS_W       = 3;

	localparam int FW_RESET = 1024;
	localparam int FH_RESET = 768;
	localparam int HS_RESET = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE    = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WIN,
		ST_FLUSH,
		ST_START,
		ST_DIV
	} bf2d_state_t;

endpackage

// ----- hw/rtl/bf2d_ram.sv -----
// generic single write port ram with registered read
module bf2d_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/bf2d_div.sv -----
// three lane restoring divider, one quotient bit per cycle
module bf2d_div #(
	parameter int SUM_W = 16,
	parameter int DV_W  = 8,
	localparam int EXT_W  = DV_W + bf2d_pkg::PIX_W,
	localparam int STEP_W = $clog2(bf2d_pkg::PIX_W)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [DV_W-1:0]                   divisor,
	input  logic [2:0][SUM_W-1:0]             sums,
	output logic                              done,
	output logic [2:0][bf2d_pkg::PIX_W-1:0]   quo
);

	import bf2d_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [EXT_W-1:0]  dsh_q;
	logic [EXT_W-1:0]  rem_q [3];
	logic [2:0][PIX_W-1:0] quo_q;
	logic [2:0]        ge;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ge[l] = rem_q[l] >= dsh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(PIX_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= EXT_W'(divisor) << (PIX_W - 1);
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= EXT_W'(sums[l]);
			end
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= ge[l] ? rem_q[l] - dsh_q : rem_q[l];
				quo_q[l] <= {quo_q[l][PIX_W-2:0], ge[l]};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hw/rtl/bf2d_ctrl.sv -----
// sequencer: raster counters, window walk, accumulation and result register
module bf2d_ctrl #(
	parameter int MAX_WIDTH = bf2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HALF  = bf2d_pkg::MAX_HALF_DEF,
	localparam int RING   = 2 * MAX_HALF + 1,
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int LINE_W = (RING > 1) ? $clog2(RING) : 1,
	localparam int KW     = (MAX_HALF > 0) ? $clog2(MAX_HALF + 1) : 1,
	localparam int DV_W   = $clog2(RING * RING + 1),
	localparam int AW     = LINE_W + COL_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [COL_W-1:0]                    w_m1,
	input  logic [bf2d_pkg::ROW_W-1:0]          h_m1,
	input  logic [KW-1:0]                       k,
	input  logic [DV_W-1:0]                     divisor,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [bf2d_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bf2d_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,
	output logic                                m_axis_tuser,
	output logic                                ram_we,
	output logic [AW-1:0]                       ram_waddr,
	output logic [bf2d_pkg::IN_DATA_W-1:0]      ram_wdata,
	output logic [AW-1:0]                       ram_raddr,
	input  logic [bf2d_pkg::IN_DATA_W-1:0]      ram_rdata
);

	import bf2d_pkg::*;

	localparam int NW    = $clog2(MAX_HALF + 2);
	localparam int SUM_W = $clog2(RING * RING * ((1 << PIX_W) - 1) + 1);
	localparam int CX_W  = COL_W + LINE_W + 1;
	localparam int LX_W  = ROW_W + 2;

	bf2d_state_t st_q, st_d;

	logic [COL_W-1:0]  in_col_q, pend_col_q, ic_q;
	logic [ROW_W-1:0]  in_row_q, pend_row_q, ir_q;
	logic [LINE_W-1:0] in_line_q, pend_line_q;
	logic              frame_loaded_q;
	logic              drain_q, stop_q, have_res_q;
	logic [NW-1:0]     n_q;
	logic [LINE_W-1:0] ci_q, cj_q;
	logic              rd_s1, ctr_s1;
	logic [2:0][SUM_W-1:0] acc_q;
	logic [PIX_W-1:0]  alpha_q;

	logic [2:0][PIX_W-1:0] res_rgb_q;
	logic [PIX_W-1:0]  res_alpha_q;
	logic [COL_W-1:0]  res_col_q;
	logic [ROW_W-1:0]  res_row_q;
	logic              res_lof_q;

	logic                  m_valid_q, m_last_q, m_user_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic                  div_start, div_done;
	logic [2:0][PIX_W-1:0] quo;

	logic accept, push, win_go, go, rdy, win_end, last_pix;
	logic [LINE_W-1:0] k2, kl;

	// window address
	logic [ROW_W:0]    rt, ru;
	logic [ROW_W-1:0]  rr;
	logic [LX_W-1:0]   le;
	logic [LINE_W-1:0] rl;
	logic [CX_W-1:0]   ct, cu;
	logic [COL_W-1:0]  cc;

	// readiness of the pending output
	logic [ROW_W:0]    nr_t;
	logic [ROW_W-1:0]  nr;
	logic [CX_W-1:0]   nc_t;
	logic [COL_W-1:0]  nc;

	assign k2 = LINE_W'({k, 1'b0});
	assign kl = LINE_W'(k);

	always_comb begin
		rt = {1'b0, pend_row_q} + (ROW_W + 1)'(cj_q);
		ru = rt - (ROW_W + 1)'(k);
		if (rt < (ROW_W + 1)'(k)) begin
			rr = '0;
		end else if (ru > {1'b0, h_m1}) begin
			rr = h_m1;
		end else begin
			rr = ru[ROW_W-1:0];
		end
		le = LX_W'(pend_line_q) + LX_W'(RING) + LX_W'(rr) - LX_W'(pend_row_q);
		if (le >= LX_W'(2 * RING)) begin
			rl = LINE_W'(le - LX_W'(2 * RING));
		end else if (le >= LX_W'(RING)) begin
			rl = LINE_W'(le - LX_W'(RING));
		end else begin
			rl = LINE_W'(le);
		end
		ct = CX_W'(pend_col_q) + CX_W'(ci_q);
		cu = ct - CX_W'(k);
		if (ct < CX_W'(k)) begin
			cc = '0;
		end else if (cu > CX_W'(w_m1)) begin
			cc = w_m1;
		end else begin
			cc = cu[COL_W-1:0];
		end
	end

	always_comb begin
		nr_t = {1'b0, pend_row_q} + (ROW_W + 1)'(k);
		nr   = (nr_t > {1'b0, h_m1}) ? h_m1 : nr_t[ROW_W-1:0];
		nc_t = CX_W'(pend_col_q) + CX_W'(k);
		nc   = (nc_t > CX_W'(w_m1)) ? w_m1 : nc_t[COL_W-1:0];
		rdy  = frame_loaded_q || (ir_q > nr) || ((ir_q == nr) && (ic_q >= nc));
		go   = !stop_q && (drain_q ? (n_q == '0) : ((n_q <= NW'(k)) && rdy));
	end

	assign win_end  = (ci_q == k2) && (cj_q == k2);
	assign last_pix = (pend_row_q == h_m1) && (pend_col_q == w_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		accept    = 1'b0;
		push      = 1'b0;
		win_go    = 1'b0;
		div_start = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					accept = 1'b1;
					if ((s_axis_tuser == OP_DRAIN) == frame_loaded_q) begin
						st_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (!(have_res_q && m_valid_q && !m_axis_tready)) begin
					push = have_res_q;
					if (go) begin
						win_go = 1'b1;
						st_d   = ST_WIN;
					end else begin
						st_d = ST_IDLE;
					end
				end
			end
			ST_WIN: begin
				if (win_end) begin
					st_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				st_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				st_d      = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					st_d = ST_CHECK;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q       <= '0;
			in_row_q       <= '0;
			in_line_q      <= '0;
			pend_col_q     <= '0;
			pend_row_q     <= '0;
			pend_line_q    <= '0;
			frame_loaded_q <= 1'b0;
			ir_q           <= '0;
			ic_q           <= '0;
			drain_q        <= 1'b0;
			stop_q         <= 1'b0;
			have_res_q     <= 1'b0;
			n_q            <= '0;
			ci_q           <= '0;
			cj_q           <= '0;
			rd_s1          <= 1'b0;
			ctr_s1         <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			rd_s1  <= (st_q == ST_WIN);
			ctr_s1 <= (st_q == ST_WIN) && (ci_q == kl) && (cj_q == kl);
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (restart) begin
				in_col_q       <= '0;
				in_row_q       <= '0;
				in_line_q      <= '0;
				pend_col_q     <= '0;
				pend_row_q     <= '0;
				pend_line_q    <= '0;
				frame_loaded_q <= 1'b0;
			end else begin
				if (accept) begin
					drain_q    <= (s_axis_tuser == OP_DRAIN);
					n_q        <= '0;
					stop_q     <= 1'b0;
					have_res_q <= 1'b0;
					if ((s_axis_tuser == OP_PIXEL) && !frame_loaded_q) begin
						ir_q <= in_row_q;
						ic_q <= in_col_q;
						if (in_col_q == w_m1) begin
							in_col_q <= '0;
							if (in_row_q == h_m1) begin
								in_row_q       <= '0;
								in_line_q      <= '0;
								frame_loaded_q <= 1'b1;
							end else begin
								in_row_q  <= in_row_q + 1'b1;
								in_line_q <= (in_line_q == LINE_W'(RING - 1)) ? '0
									: in_line_q + 1'b1;
							end
						end else begin
							in_col_q <= in_col_q + 1'b1;
						end
					end
				end
				if (win_go) begin
					ci_q <= '0;
					cj_q <= '0;
				end else if (st_q == ST_WIN) begin
					if (ci_q == k2) begin
						ci_q <= '0;
						cj_q <= cj_q + 1'b1;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				if (push) begin
					have_res_q <= 1'b0;
				end
				if (div_done) begin
					n_q        <= n_q + 1'b1;
					have_res_q <= 1'b1;
					if (last_pix) begin
						stop_q         <= 1'b1;
						in_col_q       <= '0;
						in_row_q       <= '0;
						in_line_q      <= '0;
						pend_col_q     <= '0;
						pend_row_q     <= '0;
						pend_line_q    <= '0;
						frame_loaded_q <= 1'b0;
					end else if (pend_col_q == w_m1) begin
						pend_col_q  <= '0;
						pend_row_q  <= pend_row_q + 1'b1;
						pend_line_q <= (pend_line_q == LINE_W'(RING - 1)) ? '0
							: pend_line_q + 1'b1;
					end else begin
						pend_col_q <= pend_col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_go) begin
			acc_q <= '0;
		end else if (rd_s1) begin
			for (int l = 0; l < 3; l++) begin
				acc_q[l] <= acc_q[l] + SUM_W'(ram_rdata[l*PIX_W +: PIX_W]);
			end
		end
		if (ctr_s1) begin
			alpha_q <= ram_rdata[3*PIX_W +: PIX_W];
		end
		if (div_done) begin
			res_rgb_q   <= quo;
			res_alpha_q <= alpha_q;
			res_col_q   <= pend_col_q;
			res_row_q   <= pend_row_q;
			res_lof_q   <= last_pix;
		end
		if (push) begin
			m_data_q <= {{PAD_W{1'b0}}, res_row_q, COL_OUT_W'(res_col_q), res_alpha_q,
				res_rgb_q[2], res_rgb_q[1], res_rgb_q[0]};
			m_last_q <= !go;
			m_user_q <= res_lof_q;
		end
	end

	bf2d_div #(
		.SUM_W (SUM_W),
		.DV_W  (DV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (divisor),
		.sums    (acc_q),
		.done    (div_done),
		.quo     (quo)
	);

	assign ram_we    = accept && (s_axis_tuser == OP_PIXEL) && !frame_loaded_q;
	assign ram_waddr = {in_line_q, in_col_q};
	assign ram_wdata = s_axis_tdata;
	assign ram_raddr = {rl, cc};

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ----- hw/rtl/box_filter_2d_rgba_core.sv -----
// top level of the rgba box filter: configuration registers, ring store, sequencer
//
// channel  direction  handshake              contents
// s_axis   in         tvalid / tready        pixel or drain item
// m_axis   out        tvalid / tready        filtered pixel with position and marks
// cfg      in         cfg_we                 register write, no read-back
//
// each output needs one ring store read per window pixel, 8 divide steps and the check, flush
// and start states; a pixel item emits up to h+1 outputs
// s_axis_tready is low while an item is worked on; a held result stalls the next one
// reset clears all counters; the ring store is not cleared and is never read unwritten
module box_filter_2d_rgba_core #(
	parameter int MAX_WIDTH = bf2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HALF  = bf2d_pkg::MAX_HALF_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bf2d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bf2d_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// red, green, blue, alpha
	input  logic [bf2d_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// operation
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// red_out, green_out, blue_out, alpha_out, col_out, row_out, zero fill
	output logic [bf2d_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// last_of_run
	output logic                                m_axis_tlast,
	// last_of_frame
	output logic                                m_axis_tuser
);

	import bf2d_pkg::*;

	localparam int RING   = 2 * MAX_HALF + 1;
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LINE_W = (RING > 1) ? $clog2(RING) : 1;
	localparam int KW     = (MAX_HALF > 0) ? $clog2(MAX_HALF + 1) : 1;
	localparam int DV_W   = $clog2(RING * RING + 1);
	localparam int AW     = LINE_W + COL_W;
	localparam int DEPTH  = RING * (1 << COL_W);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [HS_W-1:0] half_size_q;
	logic            restart;

	logic [COL_W-1:0]    w_m1;
	logic [ROW_W-1:0]    h_m1;
	logic [KW-1:0]       k;
	logic [KW:0]         odd;
	logic [2*KW+1:0]     sq;
	logic [DV_W-1:0]     divisor;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [IN_DATA_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(FW_RESET);
			frame_height_q <= FH_W'(FH_RESET);
			half_size_q    <= HS_W'(HS_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[FH_W-1:0];
				CFG_HALF_SIZE:    half_size_q    <= cfg_wdata[HS_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) ||
		(cfg_index == CFG_FRAME_HEIGHT) || (cfg_index == CFG_HALF_SIZE));

	always_comb begin
		if (frame_width_q == '0) begin
			w_m1 = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_W'(frame_width_q - 1'b1);
		end
		if (frame_height_q == '0) begin
			h_m1 = '0;
		end else if (frame_height_q > FH_W'(HEIGHT_MAX)) begin
			h_m1 = ROW_W'(HEIGHT_MAX - 1);
		end else begin
			h_m1 = ROW_W'(frame_height_q - 1'b1);
		end
		if (32'(half_size_q) > 32'(MAX_HALF)) begin
			k = KW'(MAX_HALF);
		end else begin
			k = KW'(half_size_q);
		end
		odd     = {k, 1'b1};
		sq      = odd * odd;
		divisor = sq[DV_W-1:0];
	end

	bf2d_ram #(
		.WIDTH  (IN_DATA_W),
		.DEPTH  (DEPTH),
		.ADDR_W (AW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bf2d_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HALF  (MAX_HALF)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.w_m1          (w_m1),
		.h_m1          (h_m1),
		.k             (k),
		.divisor       (divisor),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

endmodule
